[hw/rtl/im2col_pkg.sv]
package im2col_pkg;

  localparam int unsigned KerW     = 5;
  localparam int unsigned PadW     = 4;
  localparam int unsigned DimW     = 13;
  localparam int unsigned TotW     = DimW + 1;
  localparam int unsigned AreaW    = 2 * TotW;
  localparam int unsigned KAreaW   = 2 * KerW;
  localparam int unsigned BatchW   = 8;
  localparam int unsigned ChanW    = 10;
  localparam int unsigned SrcW     = 24;
  localparam int unsigned RowW     = 18;
  localparam int unsigned ColW     = 33;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned DivCntW  = $clog2(TotW);

  typedef enum logic [CfgIdxW-1:0] {
    REG_KERNEL_H  = 4'd0,
    REG_KERNEL_W  = 4'd1,
    REG_STRIDE_H  = 4'd2,
    REG_STRIDE_W  = 4'd3,
    REG_PAD_H     = 4'd4,
    REG_PAD_W     = 4'd5,
    REG_IN_HEIGHT = 4'd6,
    REG_IN_WIDTH  = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_PREP,
    CFG_DIV,
    CFG_TOTAL,
    CFG_AREA
  } cfg_state_e;

  typedef struct packed {
    logic [KerW-1:0]   kh;
    logic [KerW-1:0]   kw;
    logic [KerW-1:0]   sh;
    logic [KerW-1:0]   sw;
    logic [PadW-1:0]   pad_h;
    logic [PadW-1:0]   pad_w;
    logic [DimW-1:0]   ih;
    logic [DimW-1:0]   iw;
    logic [TotW-1:0]   oht;
    logic [TotW-1:0]   owt;
    logic [KAreaW-1:0] khkw;
    logic [AreaW-1:0]  area;
    logic              err;
  } geom_t;

  typedef struct packed {
    logic [KerW-1:0]   ky;
    logic [KerW-1:0]   kx;
    logic [TotW-1:0]   oy;
    logic [TotW-1:0]   ox;
    logic [BatchW-1:0] batch;
    logic [ChanW-1:0]  chan;
    logic              last;
    logic              err;
  } item_t;

  typedef struct packed {
    logic [SrcW-1:0] src;
    logic            pad;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            err;
  } result_t;

endpackage

[hw/rtl/im2col_cfg.sv]
module im2col_cfg import im2col_pkg::*; #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned MAX_KERNEL = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output logic                busy_o,
  output logic                clear_o,
  output geom_t               geom_o
);

  localparam int unsigned AccW = KerW + TotW;

  cfg_state_e state_q, state_d;

  logic [KerW-1:0] kernel_h_q, kernel_w_q, stride_h_q, stride_w_q;
  logic [PadW-1:0] pad_h_q, pad_w_q;
  logic [DimW-1:0] in_height_q, in_width_q;

  logic [AccW-1:0]    acc_h_q, acc_w_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               err_h_q, err_w_q;

  geom_t geom_q;

  logic            wr_hit;
  logic [KerW-1:0] kh_e, kw_e, sh_e, sw_e;
  logic [DimW-1:0] ih_e, iw_e;
  logic [TotW-1:0] padded_h, padded_w, num_h, num_w;
  logic            err_h, err_w;

  function automatic logic [KerW-1:0] eff_kernel(input logic [KerW-1:0] k);
    if (k == '0) return KerW'(1);
    if (32'(k) > MAX_KERNEL) return KerW'(MAX_KERNEL);
    return k;
  endfunction

  function automatic logic [KerW-1:0] eff_stride(input logic [KerW-1:0] s);
    return (s == '0) ? KerW'(1) : s;
  endfunction

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
    if (d == '0) return DimW'(1);
    if (32'(d) > MAX_DIM) return DimW'(MAX_DIM);
    return d;
  endfunction

  function automatic logic [AccW-1:0] div_step(input logic [AccW-1:0] acc,
                                               input logic [KerW-1:0] d);
    logic [KerW:0] trial;
    logic          ge;
    trial = acc[AccW-1:TotW-1];
    ge    = trial >= {1'b0, d};
    if (ge) trial = trial - {1'b0, d};
    return {trial[KerW-1:0], acc[TotW-2:0], ge};
  endfunction

  always_comb begin
    wr_hit = 1'b0;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_KERNEL_H, REG_KERNEL_W, REG_STRIDE_H, REG_STRIDE_W,
        REG_PAD_H, REG_PAD_W, REG_IN_HEIGHT, REG_IN_WIDTH: wr_hit = 1'b1;
        default: wr_hit = 1'b0;
      endcase
    end
  end

  assign clear_o = wr_hit;
  assign geom_o  = geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_h_q  <= KerW'(3);
      kernel_w_q  <= KerW'(3);
      stride_h_q  <= KerW'(1);
      stride_w_q  <= KerW'(1);
      pad_h_q     <= '0;
      pad_w_q     <= '0;
      in_height_q <= DimW'(1);
      in_width_q  <= DimW'(1);
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_KERNEL_H:  kernel_h_q  <= wr_data_i[KerW-1:0];
        REG_KERNEL_W:  kernel_w_q  <= wr_data_i[KerW-1:0];
        REG_STRIDE_H:  stride_h_q  <= wr_data_i[KerW-1:0];
        REG_STRIDE_W:  stride_w_q  <= wr_data_i[KerW-1:0];
        REG_PAD_H:     pad_h_q     <= wr_data_i[PadW-1:0];
        REG_PAD_W:     pad_w_q     <= wr_data_i[PadW-1:0];
        REG_IN_HEIGHT: in_height_q <= wr_data_i[DimW-1:0];
        REG_IN_WIDTH:  in_width_q  <= wr_data_i[DimW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    kh_e     = eff_kernel(kernel_h_q);
    kw_e     = eff_kernel(kernel_w_q);
    sh_e     = eff_stride(stride_h_q);
    sw_e     = eff_stride(stride_w_q);
    ih_e     = eff_dim(in_height_q);
    iw_e     = eff_dim(in_width_q);
    padded_h = TotW'(ih_e) + TotW'({pad_h_q, 1'b0});
    padded_w = TotW'(iw_e) + TotW'({pad_w_q, 1'b0});
    err_h    = TotW'(kh_e) > padded_h;
    err_w    = TotW'(kw_e) > padded_w;
    num_h    = err_h ? '0 : padded_h - TotW'(kh_e);
    num_w    = err_w ? '0 : padded_w - TotW'(kw_e);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    busy_o  = state_q != CFG_IDLE;
    case (state_q)
      CFG_IDLE:  state_d = CFG_IDLE;
      CFG_PREP:  state_d = CFG_DIV;
      CFG_DIV: begin
        if (div_cnt_q == DivCntW'(TotW - 1)) state_d = CFG_TOTAL;
      end
      CFG_TOTAL: state_d = CFG_AREA;
      CFG_AREA:  state_d = CFG_IDLE;
      default:   state_d = CFG_IDLE;
    endcase
    if (wr_hit) state_d = CFG_PREP;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CFG_PREP: begin
        acc_h_q   <= {{KerW{1'b0}}, num_h};
        acc_w_q   <= {{KerW{1'b0}}, num_w};
        err_h_q   <= err_h;
        err_w_q   <= err_w;
        div_cnt_q <= '0;
      end
      CFG_DIV: begin
        acc_h_q   <= div_step(acc_h_q, geom_q.sh);
        acc_w_q   <= div_step(acc_w_q, geom_q.sw);
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.kh    <= KerW'(3);
      geom_q.kw    <= KerW'(3);
      geom_q.sh    <= KerW'(1);
      geom_q.sw    <= KerW'(1);
      geom_q.pad_h <= '0;
      geom_q.pad_w <= '0;
      geom_q.ih    <= DimW'(1);
      geom_q.iw    <= DimW'(1);
      geom_q.oht   <= TotW'(1);
      geom_q.owt   <= TotW'(1);
      geom_q.khkw  <= KAreaW'(9);
      geom_q.area  <= AreaW'(1);
      geom_q.err   <= 1'b1;
    end else begin
      case (state_q)
        CFG_PREP: begin
          geom_q.kh    <= kh_e;
          geom_q.kw    <= kw_e;
          geom_q.sh    <= sh_e;
          geom_q.sw    <= sw_e;
          geom_q.pad_h <= pad_h_q;
          geom_q.pad_w <= pad_w_q;
          geom_q.ih    <= ih_e;
          geom_q.iw    <= iw_e;
          geom_q.khkw  <= KAreaW'(kh_e) * KAreaW'(kw_e);
        end
        CFG_TOTAL: begin
          geom_q.oht <= err_h_q ? TotW'(1) : acc_h_q[TotW-1:0] + TotW'(1);
          geom_q.owt <= err_w_q ? TotW'(1) : acc_w_q[TotW-1:0] + TotW'(1);
          geom_q.err <= err_h_q | err_w_q;
        end
        CFG_AREA: begin
          geom_q.area <= AreaW'(geom_q.oht) * AreaW'(geom_q.owt);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/im2col_front.sv]
module im2col_front import im2col_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_BATCH    = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              action_i,
  input  logic [BatchW-1:0] batch_i,
  input  logic [ChanW-1:0]  chan_i,
  output logic              full_o,
  input  logic              clear_i,
  input  logic              busy_i,
  input  geom_t             geom_i,
  output logic              q_valid_o,
  output item_t             q_item_o,
  input  logic              q_pop_i
);

  logic [KerW-1:0] ky_q, kx_q;
  logic [TotW-1:0] oy_q, ox_q;
  logic [KerW-1:0] cur_ky, cur_kx, ky_d, kx_d, ky_inc, kx_inc;
  logic [TotW-1:0] cur_oy, cur_ox, oy_d, ox_d, oy_inc, ox_inc;
  logic            accept;
  item_t           item;

  item_t      arr_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = busy_i || (cnt_q == 2'd2);
  assign accept    = push_i && !full_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o  = arr_q[rp_q];

  always_comb begin
    cur_ky = action_i ? ky_q : '0;
    cur_kx = action_i ? kx_q : '0;
    cur_oy = action_i ? oy_q : '0;
    cur_ox = action_i ? ox_q : '0;
    ky_inc = cur_ky + KerW'(1);
    kx_inc = cur_kx + KerW'(1);
    oy_inc = cur_oy + TotW'(1);
    ox_inc = cur_ox + TotW'(1);

    ky_d = cur_ky;
    kx_d = cur_kx;
    oy_d = cur_oy;
    ox_d = ox_inc;
    if (ox_inc >= geom_i.owt) begin
      ox_d = '0;
      oy_d = oy_inc;
      if (oy_inc >= geom_i.oht) begin
        oy_d = '0;
        kx_d = kx_inc;
        if (kx_inc >= geom_i.kw) begin
          kx_d = '0;
          ky_d = (ky_inc >= geom_i.kh) ? '0 : ky_inc;
        end
      end
    end

    item.ky    = cur_ky;
    item.kx    = cur_kx;
    item.oy    = cur_oy;
    item.ox    = cur_ox;
    item.batch = (32'(batch_i) >= MAX_BATCH) ? BatchW'(MAX_BATCH - 1) : batch_i;
    item.chan  = (32'(chan_i) >= MAX_CHANNELS) ? ChanW'(MAX_CHANNELS - 1) : chan_i;
    item.last  = (cur_ky == geom_i.kh - KerW'(1)) && (cur_kx == geom_i.kw - KerW'(1)) &&
                 (cur_oy == geom_i.oht - TotW'(1)) && (cur_ox == geom_i.owt - TotW'(1));
    item.err   = geom_i.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ky_q <= '0;
      kx_q <= '0;
      oy_q <= '0;
      ox_q <= '0;
    end else if (clear_i) begin
      ky_q <= '0;
      kx_q <= '0;
      oy_q <= '0;
      ox_q <= '0;
    end else if (accept) begin
      ky_q <= ky_d;
      kx_q <= kx_d;
      oy_q <= oy_d;
      ox_q <= ox_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (accept) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(accept) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) arr_q[wp_q] <= item;
  end

endmodule

[hw/rtl/im2col_back.sv]
module im2col_back import im2col_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  geom_t   geom_i,
  input  logic    q_valid_i,
  input  item_t   q_item_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  localparam int unsigned PyW   = TotW + KerW;
  localparam int unsigned TyW   = PyW + 1;
  localparam int unsigned ProdW = 2 * DimW;
  localparam int unsigned CrowW = ChanW + KAreaW;
  localparam int unsigned CbW   = BatchW + AreaW;

  typedef struct packed {
    logic [PyW-1:0]    py;
    logic [PyW-1:0]    px;
    logic [KerW-1:0]   ky;
    logic [KerW-1:0]   kx;
    logic [RowW-1:0]   crow;
    logic [KAreaW-1:0] krow;
    logic [ColW-1:0]   cbase;
    logic [AreaW-1:0]  orow;
    logic [TotW-1:0]   ox;
    logic              last;
    logic              err;
  } s1_t;

  typedef struct packed {
    logic [DimW-1:0] iy;
    logic [DimW-1:0] ix;
    logic            pad;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            err;
  } s2_t;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [DimW-1:0]  ix;
    logic             pad;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
    logic             err;
  } s3_t;

  logic    v1_q, v2_q, v3_q, v4_q;
  s1_t     s1_q, s1_d;
  s2_t     s2_q, s2_d;
  s3_t     s3_q, s3_d;
  result_t s4_q, s4_d;
  logic    en1, en2, en3, en4;

  logic [CrowW-1:0] crow_full;
  logic [CbW-1:0]   cbase_full;
  logic [TyW-1:0]   ty, tx, iy_full, ix_full;
  logic             pad_y, pad_x;

  result_t    of_q [2];
  logic       of_wp_q, of_rp_q;
  logic [1:0] of_cnt_q;
  logic       of_push, of_pop;

  assign of_push = v4_q && (of_cnt_q != 2'd2);
  assign of_pop  = pop_i && !empty_o;
  assign empty_o = of_cnt_q == 2'd0;
  assign result_o = of_q[of_rp_q];

  assign en4     = !v4_q || (of_cnt_q != 2'd2);
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = en1 && q_valid_i;

  always_comb begin
    s1_d.py    = PyW'(q_item_i.oy) * PyW'(geom_i.sh);
    s1_d.px    = PyW'(q_item_i.ox) * PyW'(geom_i.sw);
    s1_d.ky    = q_item_i.ky;
    s1_d.kx    = q_item_i.kx;
    crow_full  = CrowW'(q_item_i.chan) * CrowW'(geom_i.khkw);
    s1_d.crow  = crow_full[RowW-1:0];
    s1_d.krow  = KAreaW'(q_item_i.ky) * KAreaW'(geom_i.kw);
    cbase_full = CbW'(q_item_i.batch) * CbW'(geom_i.area);
    s1_d.cbase = cbase_full[ColW-1:0];
    s1_d.orow  = AreaW'(q_item_i.oy) * AreaW'(geom_i.owt);
    s1_d.ox    = q_item_i.ox;
    s1_d.last  = q_item_i.last;
    s1_d.err   = q_item_i.err;
  end

  always_comb begin
    ty      = TyW'(s1_q.py) + TyW'(s1_q.ky);
    tx      = TyW'(s1_q.px) + TyW'(s1_q.kx);
    iy_full = ty - TyW'(geom_i.pad_h);
    ix_full = tx - TyW'(geom_i.pad_w);
    pad_y   = (ty < TyW'(geom_i.pad_h)) || (iy_full >= TyW'(geom_i.ih));
    pad_x   = (tx < TyW'(geom_i.pad_w)) || (ix_full >= TyW'(geom_i.iw));
    s2_d.iy   = iy_full[DimW-1:0];
    s2_d.ix   = ix_full[DimW-1:0];
    s2_d.pad  = pad_y || pad_x;
    s2_d.row  = s1_q.crow + RowW'(s1_q.krow) + RowW'(s1_q.kx);
    s2_d.col  = s1_q.cbase + ColW'(s1_q.orow) + ColW'(s1_q.ox);
    s2_d.last = s1_q.last;
    s2_d.err  = s1_q.err;
  end

  always_comb begin
    s3_d.prod = ProdW'(s2_q.iy) * ProdW'(geom_i.iw);
    s3_d.ix   = s2_q.ix;
    s3_d.pad  = s2_q.pad;
    s3_d.row  = s2_q.row;
    s3_d.col  = s2_q.col;
    s3_d.last = s2_q.last;
    s3_d.err  = s2_q.err;
  end

  always_comb begin
    s4_d.src  = s3_q.pad ? '0 : SrcW'(s3_q.prod + ProdW'(s3_q.ix));
    s4_d.pad  = s3_q.pad;
    s4_d.row  = s3_q.row;
    s4_d.col  = s3_q.col;
    s4_d.last = s3_q.last;
    s4_d.err  = s3_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= q_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wp_q  <= 1'b0;
      of_rp_q  <= 1'b0;
      of_cnt_q <= 2'd0;
    end else begin
      if (of_push) of_wp_q <= ~of_wp_q;
      if (of_pop) of_rp_q <= ~of_rp_q;
      of_cnt_q <= of_cnt_q + 2'(of_push) - 2'(of_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_push) of_q[of_wp_q] <= s4_q;
  end

endmodule

[hw/rtl/im2col_address_generator.sv]
// Channel   Direction  Handshake                 Payload
// input     in         push / full               action, batch_index, channel_index
// result    out        empty / pop               source_offset, is_padding, dest_row,
//                                                dest_col, plane_last, config_error
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while full is low; a result reaches the output through
// the item queue, four back-end stages and the result queue.
// A register write holds full high while the output sizes are divided out
// bit-serially (14 steps) and the output area is multiplied.
// Reset leaves the register reset values and their derived sizes in place at once.
// A stalled result side fills the result and item queues, then raises full.
module im2col_address_generator import im2col_pkg::*; #(
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned MAX_KERNEL   = 16,
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_BATCH    = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                action_i,
  input  logic [BatchW-1:0]   batch_index_i,
  input  logic [ChanW-1:0]    channel_index_i,
  output logic                empty,
  input  logic                pop,
  output logic [SrcW-1:0]     source_offset_o,
  output logic                is_padding_o,
  output logic [RowW-1:0]     dest_row_o,
  output logic [ColW-1:0]     dest_col_o,
  output logic                plane_last_o,
  output logic                config_error_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  geom_t   geom;
  logic    busy, clear;
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t result;

  assign cfg_ready_o = 1'b1;

  im2col_cfg #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .busy_o     (busy),
    .clear_o    (clear),
    .geom_o     (geom)
  );

  im2col_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BATCH    (MAX_BATCH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .action_i  (action_i),
    .batch_i   (batch_index_i),
    .chan_i    (channel_index_i),
    .full_o    (full),
    .clear_i   (clear),
    .busy_i    (busy),
    .geom_i    (geom),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  im2col_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result)
  );

  assign source_offset_o = result.src;
  assign is_padding_o    = result.pad;
  assign dest_row_o      = result.row;
  assign dest_col_o      = result.col;
  assign plane_last_o    = result.last;
  assign config_error_o  = result.err;

endmodule
